// ===== rtl/md5sh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types, constants and round tables of the streaming MD5 hasher.
// ----------------------------------------------------------------------------
package md5sh_pkg;

    // Operation codes of an input beat.
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Initial chaining vector.
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    // Padding marker byte and the first buffer position of the length field.
    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;

    typedef logic [31:0] word_t;

    // Four chaining words, index 0 is a.
    typedef logic [3:0][31:0] chain_t;

    // Command from the sequencer to the compression engine.
    typedef struct packed {
        logic        start;    // one-cycle pulse: compress one block
        logic        restart;  // one-cycle pulse: reload the initial vector
        logic [6:0]  limit;    // buffer bytes below this come from memory
        logic        marker;   // byte at limit reads as the pad marker
        logic        len_en;   // words 14 and 15 carry the bit length
        logic [63:0] bit_len;  // message length in bits
    } cmd_t;

    // Status from the compression engine.
    typedef struct packed {
        logic busy;
        logic done;  // one-cycle pulse after the chaining words are updated
    } status_t;

    // Message word index used by a round.
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] j;
        logic [3:0] g;
        begin
            j = rnd[3:0];
            unique case (rnd[5:4])
                2'd0: g = j;
                2'd1: g = 4'((j << 2) + j + 4'd1);
                2'd2: g = 4'((j << 1) + j + 4'd5);
                2'd3: g = 4'((j << 3) - j);
                default: g = j;
            endcase
            return g;
        end
    endfunction

    // Left rotation amount of a round.
    function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
        logic [4:0] s;
        begin
            unique case ({rnd[5:4], rnd[1:0]})
                4'b00_00: s = 5'd7;
                4'b00_01: s = 5'd12;
                4'b00_10: s = 5'd17;
                4'b00_11: s = 5'd22;
                4'b01_00: s = 5'd5;
                4'b01_01: s = 5'd9;
                4'b01_10: s = 5'd14;
                4'b01_11: s = 5'd20;
                4'b10_00: s = 5'd4;
                4'b10_01: s = 5'd11;
                4'b10_10: s = 5'd16;
                4'b10_11: s = 5'd23;
                4'b11_00: s = 5'd6;
                4'b11_01: s = 5'd10;
                4'b11_10: s = 5'd15;
                4'b11_11: s = 5'd21;
                default:  s = 5'd7;
            endcase
            return s;
        end
    endfunction

    // Additive round constant.
    function automatic word_t round_const(input logic [5:0] rnd);
        word_t k;
        begin
            unique case (rnd)
                6'd0:  k = 32'hd76aa478;
                6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db;
                6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf;
                6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613;
                6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8;
                6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1;
                6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122;
                6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e;
                6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562;
                6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51;
                6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d;
                6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681;
                6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6;
                6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87;
                6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905;
                6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9;
                6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942;
                6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122;
                6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44;
                6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60;
                6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6;
                6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085;
                6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039;
                6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8;
                6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244;
                6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7;
                6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3;
                6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d;
                6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f;
                6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314;
                6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82;
                6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb;
                6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/md5sh_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5sh_in_if
// Message channel: one beat carries an operation and a data byte.
// ----------------------------------------------------------------------------
interface md5sh_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/md5sh_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5sh_out_if
// Digest channel: one beat carries one 32-bit digest word.
// ----------------------------------------------------------------------------
interface md5sh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        digest_last;

    modport source (output valid, output digest_word, output digest_last, input ready);
    modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/md5sh_buf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5sh_buf_ram
// 64-byte block buffer, organized as 16 words of 32 bits. One byte lane is
// written per cycle; one word is read per cycle with registered data.
// ----------------------------------------------------------------------------
module md5sh_buf_ram (
    input  wire logic        clk,
    input  wire logic        wr_en,
    input  wire logic [3:0]  wr_addr,
    input  wire logic [1:0]  wr_lane,
    input  wire logic [7:0]  wr_byte,
    input  wire logic [3:0]  rd_addr,
    output      logic [31:0] rd_data
);

    logic [31:0] mem [16];

    // Byte-lane write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_byte;
        end
    end

    // Registered word read.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/md5sh_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5sh_core
// MD5 compression engine. Reads one message word per round from the block
// buffer, substitutes padding and length on the fly, runs one round per
// cycle and folds the result into the chaining words.
// ----------------------------------------------------------------------------
module md5sh_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire md5sh_pkg::cmd_t    cmd,
    output      md5sh_pkg::status_t status,
    output      logic [3:0]         rd_addr,
    input  wire logic [31:0]        rd_data,
    output      md5sh_pkg::chain_t  chain
);
    import md5sh_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_PREF,
        C_ROUND,
        C_FOLD
    } core_state_t;

    core_state_t state_reg;
    logic [5:0]  rnd_reg;
    word_t       a_reg;
    word_t       b_reg;
    word_t       c_reg;
    word_t       d_reg;
    chain_t      chain_reg;
    logic        done_reg;

    logic [3:0]  g_cur;
    logic [5:0]  rnd_ahead;
    logic [5:0]  byte_idx;
    word_t       msg_word;
    word_t       f_val;
    word_t       t_val;
    logic [63:0] rot_wide;
    word_t       b_next;

    // Read address runs one round ahead of the datapath.
    always_comb
    begin
        g_cur     = msg_index(rnd_reg);
        rnd_ahead = (state_reg == C_PREF) ? rnd_reg : rnd_reg + 6'd1;
        rd_addr   = msg_index(rnd_ahead);
    end

    // Message word with data, pad marker, zero fill and length substituted.
    always_comb
    begin
        byte_idx = 6'd0;
        msg_word = '0;
        for (int k = 0; k < 4; k++)
        begin
            byte_idx = {g_cur, 2'(k)};
            if ({1'b0, byte_idx} < cmd.limit)
            begin
                msg_word[8*k +: 8] = rd_data[8*k +: 8];
            end
            else if (cmd.marker && ({1'b0, byte_idx} == cmd.limit))
            begin
                msg_word[8*k +: 8] = PAD_MARKER;
            end
            else
            begin
                msg_word[8*k +: 8] = 8'h00;
            end
        end
        if (cmd.len_en && (g_cur == LEN_POS[5:2]))
        begin
            msg_word = cmd.bit_len[31:0];
        end
        else if (cmd.len_en && (g_cur == LEN_POS[5:2] + 4'd1))
        begin
            msg_word = cmd.bit_len[63:32];
        end
    end

    // One MD5 round.
    always_comb
    begin
        unique case (rnd_reg[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            2'd3: f_val = c_reg ^ (b_reg | ~d_reg);
            default: f_val = '0;
        endcase
        t_val    = f_val + a_reg + round_const(rnd_reg) + msg_word;
        rot_wide = {t_val, t_val} << rot_amt(rnd_reg);
        b_next   = b_reg + rot_wide[63:32];
    end

    // Round sequencer and chaining words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            d_reg     <= '0;
            chain_reg <= {IV_D, IV_C, IV_B, IV_A};
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (cmd.restart)
                    begin
                        chain_reg <= {IV_D, IV_C, IV_B, IV_A};
                    end
                    else if (cmd.start)
                    begin
                        rnd_reg   <= '0;
                        a_reg     <= chain_reg[0];
                        b_reg     <= chain_reg[1];
                        c_reg     <= chain_reg[2];
                        d_reg     <= chain_reg[3];
                        state_reg <= C_PREF;
                    end
                end
                C_PREF:
                begin
                    state_reg <= C_ROUND;
                end
                C_ROUND:
                begin
                    a_reg   <= d_reg;
                    d_reg   <= c_reg;
                    c_reg   <= b_reg;
                    b_reg   <= b_next;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= C_FOLD;
                    end
                end
                C_FOLD:
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    done_reg     <= 1'b1;
                    state_reg    <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign chain       = chain_reg;
    assign status.busy = (state_reg != C_IDLE);
    assign status.done = done_reg;

endmodule
`default_nettype wire

// ===== rtl/md5_stream_hasher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_stream_hasher
// Streaming MD5: bytes are absorbed into a block buffer memory, each full
// block is compressed, and a finish beat pads, compresses and emits the
// digest as four words a, b, c, d.
//
//   Channel  Dir  Payload                      Beat
//   msg      in   operation, data_byte         one byte or one finish
//   digest   out  digest_word, digest_last     one digest word
//
// An absorb beat that does not fill a block leaves msg ready for more absorbs.
// The beat that fills a block is followed by its compression, in which msg is
// held off: one buffer read ahead, 64 rounds of the shared round datapath, one
// fold step. A finish compresses one block, or two when the fill level is 56 or more.
// The four digest words sit in an output register, so absorbs go on while
// they drain; a further finish waits until the last digest word is taken.
// Reset restores the initial vector and a zero byte count at once.
// ----------------------------------------------------------------------------
module md5_stream_hasher (
    input  wire logic clk,
    input  wire logic rst_n,
    md5sh_in_if.sink    msg,
    md5sh_out_if.source digest
);
    import md5sh_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BLOCK,
        S_PAD1,
        S_LAST
    } seq_state_t;

    seq_state_t  state_reg;
    logic [60:0] count_reg;
    cmd_t        cmd_reg;
    chain_t      digest_reg;
    logic [1:0]  out_idx_reg;
    logic        out_busy_reg;

    status_t     core_status;
    chain_t      core_chain;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;
    logic        in_accept;
    logic        out_accept;
    logic        wr_en;

    // Handshakes.
    always_comb
    begin
        msg.ready  = (state_reg == S_IDLE) && (!out_busy_reg || (msg.operation == OP_ABSORB));
        in_accept  = msg.valid && msg.ready;
        out_accept = digest.valid && digest.ready;
        wr_en      = in_accept && (msg.operation == OP_ABSORB);
    end

    // Block buffer memory.
    md5sh_buf_ram u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[5:2]),
        .wr_lane (count_reg[1:0]),
        .wr_byte (msg.data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Compression engine.
    md5sh_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_reg),
        .status  (core_status),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .chain   (core_chain)
    );

    // Sequencer, byte count and digest output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cmd_reg      <= '0;
            digest_reg   <= '0;
            out_idx_reg  <= '0;
            out_busy_reg <= 1'b0;
        end
        else
        begin
            cmd_reg.start   <= 1'b0;
            cmd_reg.restart <= 1'b0;

            // Drain the digest words.
            if (out_accept)
            begin
                out_idx_reg <= out_idx_reg + 2'd1;
                if (out_idx_reg == 2'd3)
                begin
                    out_busy_reg <= 1'b0;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && (msg.operation == OP_ABSORB))
                    begin
                        count_reg <= count_reg + 61'd1;
                        if (count_reg[5:0] == 6'd63)
                        begin
                            cmd_reg.start  <= 1'b1;
                            cmd_reg.limit  <= 7'd64;
                            cmd_reg.marker <= 1'b0;
                            cmd_reg.len_en <= 1'b0;
                            state_reg      <= S_BLOCK;
                        end
                    end
                    else if (in_accept)
                    begin
                        // Finish: a fill level of 56 or more needs an extra block.
                        cmd_reg.start   <= 1'b1;
                        cmd_reg.limit   <= {1'b0, count_reg[5:0]};
                        cmd_reg.marker  <= 1'b1;
                        cmd_reg.bit_len <= {count_reg, 3'b000};
                        if (count_reg[5:3] == LEN_POS[5:3])
                        begin
                            cmd_reg.len_en <= 1'b0;
                            state_reg      <= S_PAD1;
                        end
                        else
                        begin
                            cmd_reg.len_en <= 1'b1;
                            state_reg      <= S_LAST;
                        end
                    end
                end
                S_BLOCK:
                begin
                    if (core_status.done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_PAD1:
                begin
                    // Second block: zeros and the length.
                    if (core_status.done)
                    begin
                        cmd_reg.start  <= 1'b1;
                        cmd_reg.limit  <= 7'd0;
                        cmd_reg.marker <= 1'b0;
                        cmd_reg.len_en <= 1'b1;
                        state_reg      <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    if (core_status.done)
                    begin
                        digest_reg      <= core_chain;
                        out_idx_reg     <= 2'd0;
                        out_busy_reg    <= 1'b1;
                        cmd_reg.restart <= 1'b1;
                        count_reg       <= '0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Digest channel.
    always_comb
    begin
        digest.valid       = out_busy_reg;
        digest.digest_word = digest_reg[out_idx_reg];
        digest.digest_last = (out_idx_reg == 2'd3);
    end

endmodule
`default_nettype wire
